// File: design/alpp_pkg.sv
// Shared package of the ASCII position line parser.
// Holds constants, line-kind codes and the structs passed between the parts.
// No dependencies.
package alpp_pkg;

    // Line buffer limit: a line holds at most LINE_CAPACITY-1 characters
    localparam int LINE_CAPACITY = 48;
    localparam int LC_W          = $clog2(LINE_CAPACITY);

    localparam int POS_W  = 12;
    localparam int CONF_W = 7;
    localparam int SEQ_W  = 16;
    localparam int CNT_W  = 32;
    localparam int MS_W   = 32;

    // Line kinds
    localparam logic [1:0] KIND_BAD    = 2'd0;
    localparam logic [1:0] KIND_BALL   = 2'd1;
    localparam logic [1:0] KIND_NOBALL = 2'd2;
    localparam logic [1:0] KIND_TARGET = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_TARGET_MIN = 2'd0;
    localparam logic [1:0] CFG_TARGET_MAX = 2'd1;
    localparam logic [1:0] CFG_REFRESH_MS = 2'd2;

    // Characters
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_B     = 8'h42;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_X     = 8'h58;

    // Magnitude limits in hundredths
    localparam logic [11:0] POS_LIMIT  = 12'd2000;
    localparam logic [11:0] CONF_LIMIT = 12'd100;
    localparam logic [11:0] MAG_CAP    = 12'd2001;

    // One finished line, handed from the parser to the state update
    typedef struct packed {
        logic [1:0]              kind;
        logic signed [POS_W-1:0] position;
        logic signed [POS_W-1:0] value;
        logic [CONF_W-1:0]       conf;
        logic [MS_W-1:0]         now_ms;
    } t_line_evt;

    typedef struct packed {
        logic signed [POS_W-1:0] target_min;
        logic signed [POS_W-1:0] target_max;
        logic [MS_W-1:0]         refresh_ms;
    } t_cfg;

    typedef struct packed {
        logic [1:0]              line_kind;
        logic                    ball_seen;
        logic signed [POS_W-1:0] ball_position;
        logic [CONF_W-1:0]       ball_confidence;
        logic [SEQ_W-1:0]        ball_sequence;
        logic [MS_W-1:0]         ball_time_ms;
        logic                    target_present;
        logic signed [POS_W-1:0] target_position;
        logic [CNT_W-1:0]        target_version;
        logic [CNT_W-1:0]        good_lines;
        logic [CNT_W-1:0]        bad_lines;
    } t_result;

endpackage

// File: design/alpp_front.sv
// Front part: character-at-a-time line parser.
// Classifies each finished line and emits one line event. Depends on alpp_pkg.
module alpp_front
    import alpp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_accept,
    input  logic [7:0] i_rx_byte,
    input  logic [MS_W-1:0] i_now_ms,
    output logic      o_evt_push,
    output t_line_evt o_evt
);

    localparam logic [3:0] PH_START         = 4'd0;
    localparam logic [3:0] PH_B_COMMA       = 4'd1;
    localparam logic [3:0] PH_T_COMMA       = 4'd2;
    localparam logic [3:0] PH_X_COMMA       = 4'd3;
    localparam logic [3:0] PH_NUM           = 4'd4;
    localparam logic [3:0] PH_FROZEN_BALL   = 4'd5;
    localparam logic [3:0] PH_FROZEN_NOBALL = 4'd6;
    localparam logic [3:0] PH_FROZEN_TARGET = 4'd7;
    localparam logic [3:0] PH_ERROR         = 4'd8;

    localparam logic [1:0] CTX_POS   = 2'd0;
    localparam logic [1:0] CTX_BCONF = 2'd1;
    localparam logic [1:0] CTX_XCONF = 2'd2;
    localparam logic [1:0] CTX_TGT   = 2'd3;

    localparam logic [2:0] SUB_BEGIN = 3'd0;
    localparam logic [2:0] SUB_SIGN  = 3'd1;
    localparam logic [2:0] SUB_INT   = 3'd2;
    localparam logic [2:0] SUB_DOT   = 3'd3;
    localparam logic [2:0] SUB_FRAC1 = 3'd4;
    localparam logic [2:0] SUB_FRAC2 = 3'd5;

    function automatic logic [11:0] cap_mag(input logic [14:0] m);
        cap_mag = (m > 15'(POS_LIMIT)) ? MAG_CAP : m[11:0];
    endfunction

    logic [LC_W-1:0]         r_line_count, n_line_count;
    logic [3:0]              r_phase, n_phase;
    logic [1:0]              r_ctx, n_ctx;
    logic [2:0]              r_sub, n_sub;
    logic                    r_neg, n_neg;
    logic [11:0]             r_mag, n_mag;
    logic signed [POS_W-1:0] r_first, n_first;

    logic [1:0]              w_end_kind;
    logic                    w_conf_ok;
    logic signed [POS_W-1:0] w_value;
    logic                    w_dig;
    logic [3:0]              w_d;
    logic                    w_frozen;
    logic [14:0]             w_int_sum;

    assign w_conf_ok = (r_mag <= CONF_LIMIT) && !(r_neg && (r_mag != 12'd0));
    assign w_value   = r_neg ? -$signed(r_mag) : $signed(r_mag);
    assign w_dig     = (i_rx_byte >= CH_0) && (i_rx_byte <= CH_9);
    assign w_d       = w_dig ? i_rx_byte[3:0] : 4'd0;
    assign w_frozen  = (r_phase == PH_FROZEN_BALL) || (r_phase == PH_FROZEN_NOBALL) ||
                       (r_phase == PH_FROZEN_TARGET) || (r_phase == PH_ERROR);
    assign w_int_sum = 15'(r_mag) * 15'd10 + 15'(w_d) * 15'd100;

    // Kind of the line if the text ended here
    always_comb begin
        w_end_kind = KIND_BAD;
        case (r_phase)
            PH_FROZEN_BALL:   w_end_kind = KIND_BALL;
            PH_FROZEN_NOBALL: w_end_kind = KIND_NOBALL;
            PH_FROZEN_TARGET: w_end_kind = KIND_TARGET;
            PH_NUM: begin
                if (r_sub inside {SUB_INT, SUB_FRAC1, SUB_FRAC2}) begin
                    case (r_ctx)
                        CTX_BCONF: w_end_kind = w_conf_ok ? KIND_BALL : KIND_BAD;
                        CTX_XCONF: w_end_kind = w_conf_ok ? KIND_NOBALL : KIND_BAD;
                        CTX_TGT:   w_end_kind = (r_mag <= POS_LIMIT) ? KIND_TARGET : KIND_BAD;
                        default:   w_end_kind = KIND_BAD;
                    endcase
                end
            end
            default: w_end_kind = KIND_BAD;
        endcase
    end

    always_comb begin
        n_line_count = r_line_count;
        n_phase      = r_phase;
        n_ctx        = r_ctx;
        n_sub        = r_sub;
        n_neg        = r_neg;
        n_mag        = r_mag;
        n_first      = r_first;
        o_evt_push   = 1'b0;

        if (i_accept && (i_rx_byte != CH_CR)) begin
            if (i_rx_byte == CH_LF) begin
                if (r_line_count != '0) begin
                    o_evt_push   = 1'b1;
                    n_line_count = '0;
                    n_phase      = PH_START;
                end
            end else if (r_line_count < LC_W'(LINE_CAPACITY - 1)) begin
                n_line_count = r_line_count + 1'b1;
                if (!w_frozen) begin
                    if (i_rx_byte == CH_NUL) begin
                        case (w_end_kind)
                            KIND_BALL:   n_phase = PH_FROZEN_BALL;
                            KIND_NOBALL: n_phase = PH_FROZEN_NOBALL;
                            KIND_TARGET: n_phase = PH_FROZEN_TARGET;
                            default:     n_phase = PH_ERROR;
                        endcase
                    end else begin
                        case (r_phase)
                            PH_START: begin
                                n_phase = (i_rx_byte == CH_B) ? PH_B_COMMA :
                                          (i_rx_byte == CH_T) ? PH_T_COMMA : PH_ERROR;
                            end
                            PH_B_COMMA, PH_T_COMMA, PH_X_COMMA: begin
                                n_mag   = '0;
                                n_neg   = 1'b0;
                                n_sub   = SUB_BEGIN;
                                n_ctx   = (r_phase == PH_B_COMMA) ? CTX_POS :
                                          (r_phase == PH_T_COMMA) ? CTX_TGT : CTX_XCONF;
                                n_phase = (i_rx_byte == CH_COMMA) ? PH_NUM : PH_ERROR;
                            end
                            PH_NUM: begin
                                case (r_sub)
                                    SUB_BEGIN: begin
                                        if (i_rx_byte == CH_MINUS) begin
                                            n_neg = 1'b1;
                                            n_mag = '0;
                                            n_sub = SUB_SIGN;
                                        end else if (i_rx_byte == CH_PLUS) begin
                                            n_neg = 1'b0;
                                            n_mag = '0;
                                            n_sub = SUB_SIGN;
                                        end else if (w_dig) begin
                                            n_neg = 1'b0;
                                            n_mag = 12'(w_d) * 12'd100;
                                            n_sub = SUB_INT;
                                        end else if ((r_ctx == CTX_POS) && (i_rx_byte == CH_X)) begin
                                            n_phase = PH_X_COMMA;
                                        end else begin
                                            n_phase = PH_ERROR;
                                        end
                                    end
                                    SUB_SIGN: begin
                                        if (w_dig) begin
                                            n_mag = 12'(w_d) * 12'd100;
                                            n_sub = SUB_INT;
                                        end else begin
                                            n_phase = PH_ERROR;
                                        end
                                    end
                                    default: begin
                                        if (w_dig && (r_sub == SUB_INT)) begin
                                            n_mag = cap_mag(w_int_sum);
                                        end else if (w_dig && (r_sub == SUB_DOT)) begin
                                            n_mag = cap_mag(15'(r_mag) + 15'(w_d) * 15'd10);
                                            n_sub = SUB_FRAC1;
                                        end else if (w_dig && (r_sub == SUB_FRAC1)) begin
                                            n_mag = cap_mag(15'(r_mag) + 15'(w_d));
                                            n_sub = SUB_FRAC2;
                                        end else if ((i_rx_byte == CH_DOT) && (r_sub == SUB_INT)) begin
                                            n_sub = SUB_DOT;
                                        end else if ((i_rx_byte == CH_COMMA) && (r_ctx == CTX_POS) &&
                                                     (r_sub != SUB_DOT)) begin
                                            if (r_mag > POS_LIMIT) begin
                                                n_phase = PH_ERROR;
                                            end else begin
                                                n_first = w_value;
                                                n_mag   = '0;
                                                n_neg   = 1'b0;
                                                n_ctx   = CTX_BCONF;
                                                n_sub   = SUB_BEGIN;
                                            end
                                        end else begin
                                            n_phase = PH_ERROR;
                                        end
                                    end
                                endcase
                            end
                            default: n_phase = PH_ERROR;
                        endcase
                    end
                end
            end else begin
                // Overlong line: drop the byte and restart empty
                n_line_count = '0;
                n_phase      = PH_START;
            end
        end
    end

    assign o_evt.kind     = w_end_kind;
    assign o_evt.position = r_first;
    assign o_evt.value    = w_value;
    assign o_evt.conf     = r_mag[CONF_W-1:0];
    assign o_evt.now_ms   = i_now_ms;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_count <= '0;
            r_phase      <= PH_START;
            r_ctx        <= CTX_POS;
            r_sub        <= SUB_BEGIN;
            r_neg        <= 1'b0;
            r_mag        <= '0;
            r_first      <= '0;
        end else begin
            r_line_count <= n_line_count;
            r_phase      <= n_phase;
            r_ctx        <= n_ctx;
            r_sub        <= n_sub;
            r_neg        <= n_neg;
            r_mag        <= n_mag;
            r_first      <= n_first;
        end
    end

endmodule

// File: design/alpp_evt_queue.sv
// Two-entry queue of line events between the parser and the state update.
// Depends on alpp_pkg.
module alpp_evt_queue
    import alpp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_line_evt i_data,
    output logic      o_full,
    input  logic      i_pop,
    output logic      o_valid,
    output t_line_evt o_data
);

    t_line_evt  r_mem [2];
    logic       r_wr_ptr, r_rd_ptr;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

endmodule

// File: design/alpp_back.sv
// Back part: applies line events to ball, target and count state and
// queues one result snapshot per line. Depends on alpp_pkg.
module alpp_back
    import alpp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  logic      i_evt_valid,
    input  t_line_evt i_evt,
    output logic      o_evt_pop,
    output logic      o_empty,
    input  logic      i_pop,
    output t_result   o_result
);

    logic                    r_seen, n_seen;
    logic signed [POS_W-1:0] r_last_pos, n_last_pos;
    logic [CONF_W-1:0]       r_last_conf, n_last_conf;
    logic [SEQ_W-1:0]        r_seq, n_seq;
    logic [MS_W-1:0]         r_last_rx, n_last_rx;
    logic [MS_W-1:0]         r_last_meas, n_last_meas;
    logic                    r_tflag, n_tflag;
    logic signed [POS_W-1:0] r_tstore, n_tstore;
    logic [CNT_W-1:0]        r_version, n_version;
    logic [CNT_W-1:0]        r_good, n_good;
    logic [CNT_W-1:0]        r_bad, n_bad;

    t_result    r_mem [2];
    logic       r_wr_ptr, r_rd_ptr;
    logic [1:0] r_count;

    logic                    w_out_full;
    logic                    w_out_pop;
    logic [MS_W-1:0]         w_age;
    logic signed [POS_W-1:0] w_clamped;
    t_result                 w_snap;

    assign w_out_full = (r_count == 2'd2);
    assign o_empty    = (r_count == 2'd0);
    assign w_out_pop  = i_pop && !o_empty;
    assign o_evt_pop  = i_evt_valid && !w_out_full;
    assign o_result   = r_mem[r_rd_ptr];

    assign w_age = i_evt.now_ms - r_last_meas;

    always_comb begin
        if (i_evt.value < i_cfg.target_min) begin
            w_clamped = i_cfg.target_min;
        end else if (i_evt.value > i_cfg.target_max) begin
            w_clamped = i_cfg.target_max;
        end else begin
            w_clamped = i_evt.value;
        end
    end

    always_comb begin
        n_seen      = r_seen;
        n_last_pos  = r_last_pos;
        n_last_conf = r_last_conf;
        n_seq       = r_seq;
        n_last_rx   = r_last_rx;
        n_last_meas = r_last_meas;
        n_tflag     = r_tflag;
        n_tstore    = r_tstore;
        n_version   = r_version;
        n_good      = r_good;
        n_bad       = r_bad;

        if (i_evt.kind == KIND_BAD) begin
            n_bad = r_bad + 1'b1;
        end else begin
            n_good = r_good + 1'b1;
            case (i_evt.kind)
                KIND_BALL: begin
                    // Bump on first sighting, on a move, or when the position is stale
                    if (!r_seen || (i_evt.position != r_last_pos) ||
                        (w_age >= i_cfg.refresh_ms)) begin
                        n_seq       = r_seq + 1'b1;
                        n_last_meas = i_evt.now_ms;
                    end
                    n_last_pos  = i_evt.position;
                    n_last_conf = i_evt.conf;
                    n_seen      = 1'b1;
                    n_last_rx   = i_evt.now_ms;
                end
                KIND_TARGET: begin
                    if (!r_tflag || (w_clamped != r_tstore)) begin
                        n_tstore  = w_clamped;
                        n_version = r_version + 1'b1;
                    end
                    n_tflag = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        w_snap.line_kind       = i_evt.kind;
        w_snap.ball_seen       = n_seen;
        w_snap.ball_position   = n_last_pos;
        w_snap.ball_confidence = n_last_conf;
        w_snap.ball_sequence   = n_seq;
        w_snap.ball_time_ms    = n_last_rx;
        w_snap.target_present  = n_tflag;
        w_snap.target_position = n_tstore;
        w_snap.target_version  = n_version;
        w_snap.good_lines      = n_good;
        w_snap.bad_lines       = n_bad;
    end

    always_ff @(posedge i_clk) begin
        if (o_evt_pop) begin
            r_mem[r_wr_ptr] <= w_snap;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen      <= 1'b0;
            r_last_pos  <= '0;
            r_last_conf <= '0;
            r_seq       <= '0;
            r_last_rx   <= '0;
            r_last_meas <= '0;
            r_tflag     <= 1'b0;
            r_tstore    <= '0;
            r_version   <= '0;
            r_good      <= '0;
            r_bad       <= '0;
            r_wr_ptr    <= 1'b0;
            r_rd_ptr    <= 1'b0;
            r_count     <= 2'd0;
        end else begin
            if (o_evt_pop) begin
                r_seen      <= n_seen;
                r_last_pos  <= n_last_pos;
                r_last_conf <= n_last_conf;
                r_seq       <= n_seq;
                r_last_rx   <= n_last_rx;
                r_last_meas <= n_last_meas;
                r_tflag     <= n_tflag;
                r_tstore    <= n_tstore;
                r_version   <= n_version;
                r_good      <= n_good;
                r_bad       <= n_bad;
                r_wr_ptr    <= ~r_wr_ptr;
            end
            if (w_out_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + {1'b0, o_evt_pop} - {1'b0, w_out_pop};
        end
    end

endmodule

// File: design/ascii_position_line_parser_core.sv
// Top level of the ASCII position line parser.
// Instantiates alpp_front, alpp_evt_queue and alpp_back; depends on alpp_pkg.
//
//   Channel   Direction  Handshake             Payload
//   -------   ---------  --------------------  ----------------------------------
//   input     in         push / full           i_rx_byte, i_now_ms
//   result    out        empty / pop           o_line_kind ... o_bad_lines
//   config    in         i_cfg_we (no wait)    i_cfg_index, i_cfg_wdata
//
// One byte is taken per cycle while full is low. The parser handles a byte in the cycle it is
// accepted; a newline that closes a non-empty line drops a line event into a
// two-entry queue, and the state update, while the result queue has room,
// retires one event per cycle into a two-entry result queue.
// full follows only the event queue and empty only the result queue: a
// stalled reader backs up through both queues before input is held.
// Reset (synchronous, active low) clears all parser, ball, target and count
// state, empties both queues and loads the register reset values.
module ascii_position_line_parser_core
    import alpp_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,

    input  logic                    push,
    output logic                    full,
    input  logic [7:0]              i_rx_byte,
    input  logic [MS_W-1:0]         i_now_ms,

    output logic                    empty,
    input  logic                    pop,
    output logic [1:0]              o_line_kind,
    output logic                    o_ball_seen,
    output logic signed [POS_W-1:0] o_ball_position,
    output logic [CONF_W-1:0]       o_ball_confidence,
    output logic [SEQ_W-1:0]        o_ball_sequence,
    output logic [MS_W-1:0]         o_ball_time_ms,
    output logic                    o_target_present,
    output logic signed [POS_W-1:0] o_target_position,
    output logic [CNT_W-1:0]        o_target_version,
    output logic [CNT_W-1:0]        o_good_lines,
    output logic [CNT_W-1:0]        o_bad_lines,

    input  logic                    i_cfg_we,
    input  logic [1:0]              i_cfg_index,
    input  logic [31:0]             i_cfg_wdata
);

    t_cfg      r_cfg;
    logic      w_accept;
    logic      w_evt_push;
    t_line_evt w_evt_in;
    logic      w_evt_valid;
    t_line_evt w_evt_out;
    logic      w_evt_pop;
    t_result   w_result;

    assign w_accept = push && !full;

    // Configuration registers; an index past the list is ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.target_min <= -12'sd2000;
            r_cfg.target_max <= 12'sd2000;
            r_cfg.refresh_ms <= 32'd100;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_TARGET_MIN: r_cfg.target_min <= $signed(i_cfg_wdata[POS_W-1:0]);
                CFG_TARGET_MAX: r_cfg.target_max <= $signed(i_cfg_wdata[POS_W-1:0]);
                CFG_REFRESH_MS: r_cfg.refresh_ms <= i_cfg_wdata[MS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Parse bytes and classify lines
    alpp_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (w_accept),
        .i_rx_byte  (i_rx_byte),
        .i_now_ms   (i_now_ms),
        .o_evt_push (w_evt_push),
        .o_evt      (w_evt_in)
    );

    // Decouple the parser from the state update
    alpp_evt_queue u_evt_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_evt_push),
        .i_data  (w_evt_in),
        .o_full  (full),
        .i_pop   (w_evt_pop),
        .o_valid (w_evt_valid),
        .o_data  (w_evt_out)
    );

    // Apply lines to state and hold results for the reader
    alpp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_evt_valid (w_evt_valid),
        .i_evt       (w_evt_out),
        .o_evt_pop   (w_evt_pop),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_result    (w_result)
    );

    assign o_line_kind       = w_result.line_kind;
    assign o_ball_seen       = w_result.ball_seen;
    assign o_ball_position   = w_result.ball_position;
    assign o_ball_confidence = w_result.ball_confidence;
    assign o_ball_sequence   = w_result.ball_sequence;
    assign o_ball_time_ms    = w_result.ball_time_ms;
    assign o_target_present  = w_result.target_present;
    assign o_target_position = w_result.target_position;
    assign o_target_version  = w_result.target_version;
    assign o_good_lines      = w_result.good_lines;
    assign o_bad_lines       = w_result.bad_lines;

endmodule

// File: test/line_snapshot_pkg.sv
// Line snapshot predictor and scoreboard for the ASCII position line parser testbench.
// Parses the byte stream the way the core should and queues the expected snapshots.
// Depends on alpp_pkg.
package line_snapshot_pkg;
    import alpp_pkg::*;

    // Held states and the error state sit at the end of the list
    typedef enum logic [3:0] {
        PS_START, PS_B_COMMA, PS_T_COMMA, PS_X_COMMA, PS_NUMBER,
        PS_HELD_BALL, PS_HELD_NOBALL, PS_HELD_TARGET, PS_ERROR
    } t_parse_state;

    typedef enum logic [1:0] {NF_POS, NF_BCONF, NF_XCONF, NF_TARGET} t_number_field;

    typedef enum logic [2:0] {
        NS_BEGIN, NS_SIGN, NS_INT, NS_DOT, NS_FRAC1, NS_FRAC2
    } t_number_step;

    class t_line_snapshot_board;
        int              clamp_lo;
        int              clamp_hi;
        logic [MS_W-1:0] refresh_ms;

        int unsigned     line_len;
        t_parse_state    pstate;
        t_number_field   nfield;
        t_number_step    nstep;
        bit              num_neg;
        int unsigned     num_mag;
        int              ball_candidate;
        int              ball_pos;
        int              target_pos;
        logic [MS_W-1:0] refresh_base_ms;

        t_result         snap;
        t_result         snapshots_due[$];
        int              mismatches;

        function new();
            clamp_lo        = -2000;
            clamp_hi        = 2000;
            refresh_ms      = 100;
            line_len        = 0;
            pstate          = PS_START;
            nfield          = NF_POS;
            nstep           = NS_BEGIN;
            num_neg         = 1'b0;
            num_mag         = 0;
            ball_candidate  = 0;
            ball_pos        = 0;
            target_pos      = 0;
            refresh_base_ms = '0;
            snap            = '0;
            mismatches      = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] data);
            case (idx)
                CFG_TARGET_MIN: clamp_lo = $signed(data[POS_W-1:0]);
                CFG_TARGET_MAX: clamp_hi = $signed(data[POS_W-1:0]);
                CFG_REFRESH_MS: refresh_ms = data;
                default: ;
            endcase
        endfunction

        function int unsigned limit_mag(int unsigned m);
            return (m > POS_LIMIT) ? MAG_CAP : m;
        endfunction

        // Kind of the line if the text stopped right here
        function logic [1:0] kind_if_ended();
            bit conf_ok;
            conf_ok = (num_mag <= CONF_LIMIT) && !(num_neg && num_mag != 0);
            case (pstate)
                PS_HELD_BALL:   return KIND_BALL;
                PS_HELD_NOBALL: return KIND_NOBALL;
                PS_HELD_TARGET: return KIND_TARGET;
                PS_NUMBER: begin
                    if (nstep != NS_INT && nstep != NS_FRAC1 && nstep != NS_FRAC2)
                        return KIND_BAD;
                    case (nfield)
                        NF_BCONF:  return conf_ok ? KIND_BALL : KIND_BAD;
                        NF_XCONF:  return conf_ok ? KIND_NOBALL : KIND_BAD;
                        NF_TARGET: return (num_mag <= POS_LIMIT) ? KIND_TARGET : KIND_BAD;
                        default:   return KIND_BAD;
                    endcase
                end
                default: return KIND_BAD;
            endcase
        endfunction

        function void open_number(t_number_field f, logic [7:0] c);
            num_neg = 1'b0;
            num_mag = 0;
            if (c == CH_COMMA) begin
                pstate = PS_NUMBER;
                nfield = f;
                nstep  = NS_BEGIN;
            end else begin
                pstate = PS_ERROR;
            end
        endfunction

        function void number_char(logic [7:0] c);
            bit          is_digit;
            int unsigned d;
            is_digit = (c >= CH_0) && (c <= CH_9);
            d = is_digit ? int'(c - CH_0) : 0;
            case (nstep)
                NS_BEGIN: begin
                    if (c == CH_MINUS) begin
                        num_neg = 1'b1;
                        num_mag = 0;
                        nstep   = NS_SIGN;
                    end else if (c == CH_PLUS) begin
                        num_neg = 1'b0;
                        num_mag = 0;
                        nstep   = NS_SIGN;
                    end else if (is_digit) begin
                        num_neg = 1'b0;
                        num_mag = d * 100;
                        nstep   = NS_INT;
                    end else if (nfield == NF_POS && c == CH_X) begin
                        pstate = PS_X_COMMA;
                    end else begin
                        pstate = PS_ERROR;
                    end
                end
                NS_SIGN: begin
                    if (is_digit) begin
                        num_mag = d * 100;
                        nstep   = NS_INT;
                    end else begin
                        pstate = PS_ERROR;
                    end
                end
                default: begin
                    if (is_digit && nstep == NS_INT) begin
                        num_mag = limit_mag(num_mag * 10 + d * 100);
                    end else if (is_digit && nstep == NS_DOT) begin
                        num_mag = limit_mag(num_mag + d * 10);
                        nstep   = NS_FRAC1;
                    end else if (is_digit && nstep == NS_FRAC1) begin
                        num_mag = limit_mag(num_mag + d);
                        nstep   = NS_FRAC2;
                    end else if (c == CH_DOT && nstep == NS_INT) begin
                        nstep = NS_DOT;
                    end else if (c == CH_COMMA && nfield == NF_POS && nstep != NS_DOT) begin
                        if (num_mag > POS_LIMIT) begin
                            pstate = PS_ERROR;
                        end else begin
                            ball_candidate = num_neg ? -int'(num_mag) : int'(num_mag);
                            num_neg = 1'b0;
                            num_mag = 0;
                            nfield  = NF_BCONF;
                            nstep   = NS_BEGIN;
                        end
                    end else begin
                        pstate = PS_ERROR;
                    end
                end
            endcase
        endfunction

        function void take_char(logic [7:0] c);
            logic [1:0] k;
            if (pstate >= PS_HELD_BALL)
                return;
            if (c == CH_NUL) begin
                k = kind_if_ended();
                case (k)
                    KIND_BALL:   pstate = PS_HELD_BALL;
                    KIND_NOBALL: pstate = PS_HELD_NOBALL;
                    KIND_TARGET: pstate = PS_HELD_TARGET;
                    default:     pstate = PS_ERROR;
                endcase
                return;
            end
            case (pstate)
                PS_START: begin
                    if (c == CH_B)
                        pstate = PS_B_COMMA;
                    else if (c == CH_T)
                        pstate = PS_T_COMMA;
                    else
                        pstate = PS_ERROR;
                end
                PS_B_COMMA: open_number(NF_POS, c);
                PS_T_COMMA: open_number(NF_TARGET, c);
                PS_X_COMMA: open_number(NF_XCONF, c);
                default:    number_char(c);
            endcase
        endfunction

        // Note one accepted input transaction; a newline closing a line queues a snapshot
        function void accept_byte(logic [7:0] c, logic [MS_W-1:0] now);
            logic [1:0] kind;
            int         t;
            if (c == CH_CR)
                return;
            if (c != CH_LF) begin
                if (line_len < LINE_CAPACITY - 1) begin
                    line_len++;
                    take_char(c);
                end else begin
                    line_len = 0;
                    pstate   = PS_START;
                end
                return;
            end
            if (line_len == 0)
                return;

            kind = kind_if_ended();
            if (kind == KIND_BAD) begin
                snap.bad_lines++;
            end else begin
                snap.good_lines++;
                if (kind == KIND_BALL) begin
                    if (!snap.ball_seen || ball_candidate != ball_pos ||
                        (now - refresh_base_ms) >= refresh_ms) begin
                        snap.ball_sequence++;
                        refresh_base_ms = now;
                    end
                    ball_pos             = ball_candidate;
                    snap.ball_position   = ball_pos[POS_W-1:0];
                    snap.ball_confidence = num_mag[CONF_W-1:0];
                    snap.ball_seen       = 1'b1;
                    snap.ball_time_ms    = now;
                end else if (kind == KIND_TARGET) begin
                    t = num_neg ? -int'(num_mag) : int'(num_mag);
                    if (t < clamp_lo)
                        t = clamp_lo;
                    else if (t > clamp_hi)
                        t = clamp_hi;
                    if (!snap.target_present || t != target_pos) begin
                        target_pos           = t;
                        snap.target_position = t[POS_W-1:0];
                        snap.target_version++;
                    end
                    snap.target_present = 1'b1;
                end
            end
            snap.line_kind = kind;
            snapshots_due.push_back(snap);
            line_len = 0;
            pstate   = PS_START;
        endfunction

        function void compare_field(string name, logic signed [63:0] want,
                                    logic signed [63:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                mismatches++;
            end
        endfunction

        // Check one accepted result transaction against the oldest snapshot due
        function void check_snapshot(t_result got);
            t_result want;
            if (snapshots_due.size() == 0) begin
                $error("line snapshot popped with none expected");
                mismatches++;
                return;
            end
            want = snapshots_due.pop_front();
            compare_field("line_kind", want.line_kind, got.line_kind);
            compare_field("ball_seen", want.ball_seen, got.ball_seen);
            compare_field("ball_position", $signed(want.ball_position),
                          $signed(got.ball_position));
            compare_field("ball_confidence", want.ball_confidence, got.ball_confidence);
            compare_field("ball_sequence", want.ball_sequence, got.ball_sequence);
            compare_field("ball_time_ms", want.ball_time_ms, got.ball_time_ms);
            compare_field("target_present", want.target_present, got.target_present);
            compare_field("target_position", $signed(want.target_position),
                          $signed(got.target_position));
            compare_field("target_version", want.target_version, got.target_version);
            compare_field("good_lines", want.good_lines, got.good_lines);
            compare_field("bad_lines", want.bad_lines, got.bad_lines);
        endfunction
    endclass

endpackage

// File: test/tb_ascii_position_line_parser_core.sv
// Testbench of ascii_position_line_parser_core: directed and random text lines with
// random idle gaps on both sides, every line snapshot predicted and checked.
// Depends on alpp_pkg, line_snapshot_pkg and the core RTL.
module tb_ascii_position_line_parser_core;
    timeunit 1ns;
    timeprecision 1ps;

    import alpp_pkg::*;
    import line_snapshot_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 200000;
    localparam int          SETTLE_CYCLES = 8;    // result passes through both queues after its newline
    localparam int          HOLD_CYCLES   = 120;  // long reader hold-off
    localparam int          PHASE_BYTES   = 65;   // random bytes per configuration phase, at least

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    push;
    logic                    full;
    logic [7:0]              i_rx_byte;
    logic [MS_W-1:0]         i_now_ms;
    logic                    empty;
    logic                    pop;
    logic [1:0]              o_line_kind;
    logic                    o_ball_seen;
    logic signed [POS_W-1:0] o_ball_position;
    logic [CONF_W-1:0]       o_ball_confidence;
    logic [SEQ_W-1:0]        o_ball_sequence;
    logic [MS_W-1:0]         o_ball_time_ms;
    logic                    o_target_present;
    logic signed [POS_W-1:0] o_target_position;
    logic [CNT_W-1:0]        o_target_version;
    logic [CNT_W-1:0]        o_good_lines;
    logic [CNT_W-1:0]        o_bad_lines;
    logic                    i_cfg_we;
    logic [1:0]              i_cfg_index;
    logic [31:0]             i_cfg_wdata;

    t_result              out_snap;
    t_line_snapshot_board board = new();

    logic [MS_W-1:0] now_ms = '0;
    int unsigned     bytes_sent = 0;
    int unsigned     cycle_count = 0;
    bit              tx_gaps = 1'b0;
    bit              rx_gaps = 1'b0;
    bit              hold_off_req = 1'b0;
    string           held_pos = "";

    ascii_position_line_parser_core DUT (.*);

    // Result ports packed in field order of the snapshot struct
    assign out_snap = {o_line_kind, o_ball_seen, o_ball_position, o_ball_confidence,
                       o_ball_sequence, o_ball_time_ms, o_target_present,
                       o_target_position, o_target_version, o_good_lines, o_bad_lines};

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Sample every handshake at the rising edge; inputs only move at the falling edge,
    // so the values seen here are the ones the core takes.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we)
                board.set_reg(i_cfg_index, i_cfg_wdata);
            if (push && !full)
                board.accept_byte(i_rx_byte, i_now_ms);
            if (pop && !empty)
                board.check_snapshot(out_snap);
        end
        cycle_count++;
        // Bail out if the core hangs or a snapshot never shows
        if (cycle_count > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Result side: pop by default, drop it for short random bursts, and hold off for a
    // long stretch when asked so that both internal queues fill and full rises.
    initial begin
        pop = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_req) begin
                pop = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_off_req = 1'b0;
            end else if (rx_gaps && $urandom_range(0, 5) == 0) begin
                pop = 1'b0;
                repeat ($urandom_range(1, 5)) @(negedge i_clk);
            end
            pop = 1'b1;
        end
    end

    // Offer one byte and hold it until the core takes it; an idle gap now and then goes in
    // ahead of the byte when sender gaps are on.
    task automatic send_char(logic [7:0] c);
        @(negedge i_clk);
        if (tx_gaps && $urandom_range(0, 5) == 0) begin
            push = 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge i_clk);
        end
        push      = 1'b1;
        i_rx_byte = c;
        i_now_ms  = now_ms;
        now_ms += $urandom_range(0, 2);
        do begin
            @(posedge i_clk);
        end while (full);
        bytes_sent++;
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i]);
    endtask

    // Advance the clock in ms, now and then with a big jump or close to the wrap,
    // then send the text and close it with LF or CR LF.
    task automatic send_line(string body);
        case ($urandom_range(0, 39))
            0:       now_ms = $urandom();
            1:       now_ms = 32'hFFFF_FF00 + $urandom_range(0, 255);
            default: now_ms += $urandom_range(0, 150);
        endcase
        send_text(body);
        if ($urandom_range(0, 3) == 0)
            send_char(CH_CR);
        send_char(CH_LF);
    endtask

    // Signed decimal in several spellings: bare integer, one or two decimals,
    // leading zero, optional plus or minus sign.
    function automatic string rand_number(int unsigned hi_mag);
        int unsigned m;
        string       sign;
        string       s;
        m = $urandom_range(0, hi_mag);
        case ($urandom_range(0, 7))
            0:       sign = "-";
            1:       sign = "+";
            default: sign = "";
        endcase
        case ($urandom_range(0, 3))
            0:       s = $sformatf("%0d", m / 100);
            1:       s = $sformatf("%0d.%0d", m / 100, (m % 100) / 10);
            2:       s = $sformatf("%0d.%02d", m / 100, m % 100);
            default: s = $sformatf("0%0d.%02d", m / 100, m % 100);
        endcase
        return {sign, s};
    endfunction

    // Mostly well-formed ball, no-ball and target lines with random content; the rest
    // are corrupted, cut by a zero byte, split by a CR, noise, overlong or empty.
    task automatic send_random_line();
        string       body;
        string       pos_text;
        int unsigned pick;
        int unsigned cut;
        // Reuse the last position often so that the stationary refresh path gets hit
        if ($urandom_range(0, 2) != 0 && held_pos != "") begin
            pos_text = held_pos;
        end else begin
            pos_text = rand_number(($urandom_range(0, 9) == 0) ? 2600 : 2000);
            held_pos = pos_text;
        end
        pick = $urandom_range(0, 99);
        if (pick < 40)
            body = {"B,", pos_text, ",", rand_number(($urandom_range(0, 9) == 0) ? 180 : 100)};
        else if (pick < 55)
            body = {"B,X,", rand_number(($urandom_range(0, 9) == 0) ? 180 : 100)};
        else
            body = {"T,", rand_number(($urandom_range(0, 9) == 0) ? 2300 : 2000)};

        cut  = $urandom_range(0, body.len() - 1);
        pick = $urandom_range(0, 99);
        if (pick < 72) begin
            send_line(body);
        end else if (pick < 80) begin
            // Truncate, or overwrite one character with a printable one
            if ($urandom_range(0, 1) == 0)
                body = body.substr(0, cut - 1);
            else
                body.putc(cut, 8'($urandom_range(32, 126)));
            send_line(body);
        end else if (pick < 85) begin
            send_text(body.substr(0, cut));
            send_char(CH_NUL);
            send_line(rand_number(2000));
        end else if (pick < 90) begin
            repeat ($urandom_range(1, 12))
                send_char(8'($urandom_range(0, 255)));
            send_line("");
        end else if (pick < 94) begin
            send_text(body.substr(0, cut - 1));
            send_char(CH_CR);
            send_line(body.substr(cut, body.len() - 1));
        end else if (pick < 97) begin
            // Long digit run ahead of the body; past the line capacity the line restarts
            repeat ($urandom_range(40, 60))
                send_char(CH_0 + 8'($urandom_range(0, 9)));
            send_line(body);
        end else begin
            send_line("");
        end
    endtask

    // Drop push and wait until every snapshot is in, then let the core settle
    task automatic wait_idle();
        @(negedge i_clk);
        push = 1'b0;
        while (board.snapshots_due.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic cfg_write(logic [1:0] idx, logic [31:0] value);
        @(negedge i_clk);
        push        = 1'b0;
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_wdata = value;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    initial begin
        int          lo_set[5];
        int          hi_set[5];
        logic [31:0] refresh_set[5];
        int unsigned goal;

        push        = 1'b0;
        i_rx_byte   = '0;
        i_now_ms    = '0;
        i_cfg_we    = 1'b0;
        i_cfg_index = CFG_TARGET_MIN;
        i_cfg_wdata = '0;
        i_rst_n     = 1'b0;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed lines at reset settings
        send_line("");
        send_line("B,20.00,1.00");
        send_line("B,20,100");
        send_line("B,-20.00,0");
        send_line("B,X,-0.00");
        send_line("B,-0,-0");
        send_line("B,20.01,50");
        send_line("T,99999");
        send_line("T,-15.5");
        send_line("T,+20.00");
        send_line("B,1.5,101");
        send_line("B,1.,5");
        send_text("T,12");
        send_char(CH_NUL);
        send_line("zz");
        send_char(CH_NUL);
        send_line("");
        // Fill the line, then one more byte: it is dropped and the line restarts
        repeat (LINE_CAPACITY - 1) send_char(CH_0 + 8'd7);
        send_char(CH_T);
        send_line("T,3");
        send_line("T,1.");
        send_line("Q");
        send_line("B,,1");
        send_text("T,");
        send_char(CH_CR);
        send_line("5");
        send_line("B,X,1.234");

        // Settings per phase: narrow window, inverted window, extremes, random, reset values
        lo_set      = '{-500, 300, -2000, 0, -2000};
        hi_set      = '{700, -300, 2000, 0, 2000};
        refresh_set = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd0, 32'd100};
        lo_set[3]      = int'($urandom_range(0, 4000)) - 2000;
        hi_set[3]      = int'($urandom_range(0, 4000)) - 2000;
        refresh_set[3] = $urandom_range(0, 200);

        for (int p = 0; p < 5; p++) begin
            wait_idle();
            cfg_write(CFG_TARGET_MIN, lo_set[p]);
            cfg_write(CFG_TARGET_MAX, hi_set[p]);
            cfg_write(CFG_REFRESH_MS, refresh_set[p]);
            // No gaps in the third phase and in the last one
            tx_gaps = (p != 2 && p != 4);
            rx_gaps = tx_gaps;
            goal = bytes_sent + PHASE_BYTES;
            while (bytes_sent < goal)
                send_random_line();
            if (p == 0) begin
                // Stall the reader while short target lines keep coming, so that full rises
                wait_idle();
                tx_gaps      = 1'b0;
                hold_off_req = 1'b1;
                repeat (12) send_line({"T,", rand_number(2000)});
            end
        end

        wait_idle();
        if (board.mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
